FILE: hdl/ipck_pkg.sv
package ipck_pkg;

   localparam logic [1:0] MODE_HEADER    = 2'd0;
   localparam logic [1:0] MODE_TRANSPORT = 2'd1;
   localparam logic [1:0] MODE_PLAIN     = 2'd2;

   localparam logic [14:0] INDEX_MAX = 15'h7FFF;
   localparam logic [3:0]  IHL_MIN   = 4'd5;

   typedef struct packed {
      logic [15:0] word;
      logic        last;
      logic        odd_tail;
   } item_type;

   typedef struct packed {
      logic [15:0] checksum;
      logic        short_error;
   } result_type;

   // ones' complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [16:0] f;
      s = {1'b0, a} + {1'b0, b};
      f = {1'b0, s[15:0]} + {16'd0, s[16]};
      return f[15:0];
   endfunction

endpackage

FILE: hdl/ipck_accum.sv
module ipck_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  ipck_pkg::item_type    item,
   input  logic [1:0]            mode,
   output ipck_pkg::result_type  result
);

   logic [15:0] sum_ff, sum_in;
   logic [15:0] pseudo_ff, pseudo_in;
   logic [14:0] index_ff, index_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [15:0] tot_ff, tot_in;

   logic [3:0]  ihl;
   logic [15:0] tlen;
   logic [3:0]  ihl_eff;
   logic [4:0]  ihl_words;
   logic [4:0]  hdr_words;
   logic [5:0]  hdr_bytes;
   logic [15:0] idx2;
   logic [15:0] count;
   logic [16:0] count2;
   logic [15:0] word_hi;
   logic [15:0] plen;
   logic [15:0] acc;
   logic [15:0] final_sum;
   logic        is_short;

   always_comb begin
      ihl       = (index_ff == 15'd0) ? item.word[11:8] : ihl_ff;
      tlen      = (index_ff == 15'd1) ? item.word : tot_ff;
      ihl_eff   = (ihl < ipck_pkg::IHL_MIN) ? ipck_pkg::IHL_MIN : ihl;
      ihl_words = {ihl, 1'b0};
      hdr_words = {ihl_eff, 1'b0};
      hdr_bytes = {ihl_eff, 2'b00};
      idx2      = {index_ff, 1'b0};
      count     = {1'b0, index_ff} + 16'd1;
      count2    = {count, 1'b0};
      word_hi   = {item.word[15:8], 8'h00};
      plen      = (tlen > {10'd0, hdr_bytes}) ? (tlen - {10'd0, hdr_bytes}) : 16'd0;

      sum_in    = sum_ff;
      pseudo_in = pseudo_ff;
      case (mode)
         ipck_pkg::MODE_HEADER: begin
            if (index_ff < {10'd0, ihl_words})
               sum_in = ipck_pkg::oc_add(sum_ff, item.word);
         end
         ipck_pkg::MODE_TRANSPORT: begin
            if (index_ff == 15'd4)
               pseudo_in = ipck_pkg::oc_add(pseudo_ff, {8'h00, item.word[7:0]});
            if (index_ff inside {[15'd6 : 15'd9]})
               pseudo_in = ipck_pkg::oc_add(pseudo_ff, item.word);
            if ((index_ff >= {10'd0, hdr_words}) && (idx2 < tlen))
               sum_in = ipck_pkg::oc_add(sum_ff,
                  ({index_ff, 1'b1} == tlen) ? word_hi : item.word);
         end
         default: begin
            sum_in = ipck_pkg::oc_add(sum_ff,
               (item.last && item.odd_tail) ? word_hi : item.word);
         end
      endcase

      acc       = ipck_pkg::oc_add(sum_in, pseudo_in);
      final_sum = sum_in;
      is_short  = 1'b0;
      case (mode)
         ipck_pkg::MODE_HEADER: begin
            is_short = count < {11'd0, ihl_words};
         end
         ipck_pkg::MODE_TRANSPORT: begin
            final_sum = ipck_pkg::oc_add(acc, plen);
            is_short  = (count < {11'd0, hdr_words}) || (count2 < {1'b0, tlen});
         end
         default: begin
            is_short = 1'b0;
         end
      endcase

      result.checksum    = ~final_sum;
      result.short_error = is_short;

      index_in = (index_ff != ipck_pkg::INDEX_MAX) ? index_ff + 15'd1 : index_ff;
      ihl_in   = ihl;
      tot_in   = tlen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= 16'd0;
         pseudo_ff <= 16'd0;
         index_ff  <= 15'd0;
         ihl_ff    <= 4'd0;
         tot_ff    <= 16'd0;
      end else if (step) begin
         if (item.last) begin
            sum_ff    <= 16'd0;
            pseudo_ff <= 16'd0;
            index_ff  <= 15'd0;
            ihl_ff    <= 4'd0;
            tot_ff    <= 16'd0;
         end else begin
            sum_ff    <= sum_in;
            pseudo_ff <= pseudo_in;
            index_ff  <= index_in;
            ihl_ff    <= ihl_in;
            tot_ff    <= tot_in;
         end
      end
   end

   a_index_clear: assert property (@(posedge clock) disable iff (reset)
      step && item.last |=> index_ff == 15'd0)
      else $error("word index not cleared after final word");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      step && !item.last && (index_ff != ipck_pkg::INDEX_MAX)
      |=> index_ff == $past(index_ff) + 15'd1)
      else $error("word index did not advance");

   a_sums_clear: assert property (@(posedge clock) disable iff (reset)
      step && item.last |=> sum_ff == 16'd0 && pseudo_ff == 16'd0 && ihl_ff == 4'd0)
      else $error("packet state not cleared after final word");

endmodule

FILE: hdl/ipv4_packet_checksum_unit.sv
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_word, req_last, req_odd_tail
// rsp      out        rsp_valid/rsp_ready  rsp_checksum, rsp_short_error
// csr      in         csr_we               csr_wdata (mode)
//
// one word per cycle while no held result stalls a final word
// input register feeds one accumulate stage, result register holds the checksum
// synchronous active-high reset clears valids, mode and packet state
// a held result stalls only a final word; other words keep flowing
module ipv4_packet_checksum_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_word,
   input  logic        req_last,
   input  logic        req_odd_tail,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_checksum,
   output logic        rsp_short_error,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   ipck_pkg::item_type   in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   ipck_pkg::result_type out_result_ff;
   logic [1:0]           mode_ff;
   ipck_pkg::result_type result;
   logic                 advance;

   assign advance     = in_valid_ff && (!in_item_ff.last || !out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_valid || (in_valid_ff && !advance);
   assign out_valid_in = (advance && in_item_ff.last) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ipck_pkg::MODE_HEADER;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.word     <= req_word;
         in_item_ff.last     <= req_last;
         in_item_ff.odd_tail <= req_odd_tail;
      end
      if (advance && in_item_ff.last) begin
         out_result_ff <= result;
      end
   end

   ipck_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .mode   (mode_ff),
      .result (result)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_checksum    = out_result_ff.checksum;
   assign rsp_short_error = out_result_ff.short_error;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_item_ff.last && out_valid_ff && !rsp_ready |-> !advance && !req_ready)
      else $error("final word would overwrite a pending result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff ##1 out_valid_ff |-> $past(advance && in_item_ff.last))
      else $error("result without a final word");

   a_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled input word lost");

endmodule
